// File: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and types of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int BLOCK_SIZE  = 64;
   localparam int BLOCK_COUNT = 16;
   localparam int CAPACITY    = BLOCK_COUNT * BLOCK_SIZE;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int SUM_W       = COUNT_W + 1;
   localparam int DATA_W      = 32;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int FILL_W      = 11;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [ADDR_W-1:0]  HEAD_RESET = ADDR_W'(CAPACITY / 2);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAPACITY);

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] front_addr;
      logic [ADDR_W-1:0] back_addr;
   } ram_cmd_type;

   typedef struct packed {
      logic                strobe;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } rsp_info_type;

   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s >= SUM_W'(CAPACITY)) begin
         s = s - SUM_W'(CAPACITY);
      end
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == '0) begin
         r = ADDR_W'(CAPACITY - 1);
      end else begin
         r = a - 1'b1;
      end
      return r;
   endfunction

endpackage

// File: hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity deque of 32-bit signed words held in one ring memory.
// ----------------------------------------------------------------------------
// One operation is accepted in every clock cycle: busy is high only while
// reset is applied. The result word of an operation appears on the rsp_
// ports, marked by rsp_strobe, in the cycle after it is accepted; the wait is
// for the registered read of the ring memory, which returns the new front
// and back words while the pointers and the write are already settled. The
// memory needs no clearing pass after reset, so operations may start in the
// first cycle after reset is released.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [DATA_W-1:0]   req_push_value,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_is_empty,
   output logic [FILL_W-1:0]          rsp_fill_count,
   output logic signed [DATA_W-1:0]   rsp_front_value,
   output logic signed [DATA_W-1:0]   rsp_back_value
);

   logic              accept;
   ram_cmd_type       ram_cmd;
   rsp_info_type      rsp_info;
   logic [DATA_W-1:0] front_word;
   logic [DATA_W-1:0] back_word;
   logic              empty;

   assign busy   = reset;
   assign accept = start && !busy;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_mode),
      .push_value (req_push_value),
      .ram_cmd    (ram_cmd),
      .rsp_info   (rsp_info)
   );

   dq_ram #(
      .DATA_W (DATA_W),
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_cmd.wr_en),
      .wr_addr   (ram_cmd.wr_addr),
      .wr_data   (ram_cmd.wr_data),
      .rd_en     (ram_cmd.rd_en),
      .rd_addr_a (ram_cmd.front_addr),
      .rd_addr_b (ram_cmd.back_addr),
      .rd_data_a (front_word),
      .rd_data_b (back_word)
   );

   assign empty           = (rsp_info.count == '0);
   assign rsp_strobe      = rsp_info.strobe;
   assign rsp_status      = rsp_info.status;
   assign rsp_is_empty    = empty;
   assign rsp_fill_count  = FILL_W'(rsp_info.count);
   assign rsp_front_value = empty ? '0 : front_word;
   assign rsp_back_value  = empty ? '0 : back_word;

endmodule

// File: hdl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Synchronous memory with one write port and two read ports, registered read
// data and write-first behaviour when a read meets the word being written.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_a_ff;
   logic [DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_data_a_ff <= wr_data;
         end else begin
            rd_data_a_ff <= mem[rd_addr_a];
         end
         if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_data_b_ff <= wr_data;
         end else begin
            rd_data_b_ff <= mem[rd_addr_b];
         end
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Head pointer and element count. Decodes each operation, issues the memory
// write and the reads of the new front and back words.
// ----------------------------------------------------------------------------
module dq_ctrl
   import dq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [MODE_W-1:0]  mode,
   input  logic [DATA_W-1:0]  push_value,
   output ram_cmd_type        ram_cmd,
   output rsp_info_type       rsp_info
);

   logic [ADDR_W-1:0]   head_ff;
   logic [ADDR_W-1:0]   head_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                strobe_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic                is_full;
   logic                is_empty;

   assign is_full  = (count_ff >= COUNT_FULL);
   assign is_empty = (count_ff == '0);

   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      status_in        = STATUS_DONE;
      ram_cmd.rd_en    = accept;
      ram_cmd.wr_en    = 1'b0;
      ram_cmd.wr_addr  = head_ff;
      ram_cmd.wr_data  = push_value;
      if (accept) begin
         unique case (mode)
            MODE_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  head_in         = ring_prev(head_ff);
                  ram_cmd.wr_en   = 1'b1;
                  ram_cmd.wr_addr = head_in;
                  count_in        = count_ff + 1'b1;
               end
            end
            MODE_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ram_cmd.wr_en   = 1'b1;
                  ram_cmd.wr_addr = ring_add(head_ff, count_ff);
                  count_in        = count_ff + 1'b1;
               end
            end
            MODE_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  head_in  = ring_add(head_ff, COUNT_W'(1));
                  count_in = count_ff - 1'b1;
               end
            end
            MODE_POP_BACK: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            MODE_CLEAR: begin
               head_in  = HEAD_RESET;
               count_in = '0;
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
      ram_cmd.front_addr = head_in;
      if (count_in == '0) begin
         ram_cmd.back_addr = head_in;
      end else begin
         ram_cmd.back_addr = ring_add(head_in, count_in - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= HEAD_RESET;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         status_ff <= STATUS_DONE;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= accept;
         status_ff <= status_in;
      end
   end

   assign rsp_info.strobe = strobe_ff;
   assign rsp_info.status = status_ff;
   assign rsp_info.count  = count_ff;

endmodule

// File: hdl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker
   import dq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     rsp_strobe,
   input  logic                     rsp_is_empty,
   input  logic [FILL_W-1:0]        rsp_fill_count,
   input  logic signed [DATA_W-1:0] rsp_front_value,
   input  logic signed [DATA_W-1:0] rsp_back_value
);

   a_one_word_per_op: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_strobe == $past(start && !busy)))
      else $error("A result word does not follow its operation by one cycle.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_fill_count == '0)))
      else $error("The empty flag disagrees with the fill count.");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_empty) |-> (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("An empty deque reports a front or back word.");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_fill_count <= FILL_W'(CAPACITY)))
      else $error("The fill count exceeds the capacity.");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fill_count == FILL_W'(1)) |-> (rsp_front_value == rsp_back_value))
      else $error("A single element has differing front and back words.");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_fill_count  (rsp_fill_count),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value)
);
